/* design/rwl_pkg.sv */
// shared types and constants for the reader-writer lock unit
`timescale 1ns / 1ps

package rwl_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned IdW       = 6;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CountW    = 8;
  localparam int unsigned IdMaxBits = 16;

  // default sizing
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 6;

  // most woken ids sent out for one release
  localparam int unsigned MaxResults = 16;
  localparam int unsigned WakeCntW   = $clog2(MaxResults);

  typedef enum logic [1:0] {
    ACT_RD_LOCK   = 2'd0,
    ACT_RD_UNLOCK = 2'd1,
    ACT_WR_LOCK   = 2'd2,
    ACT_WR_UNLOCK = 2'd3
  } action_e;

  typedef enum logic [ModeW-1:0] {
    MODE_FREE    = 2'd0,
    MODE_READING = 2'd1,
    MODE_WRITING = 2'd2
  } mode_e;

  typedef enum logic [KindW-1:0] {
    EV_GRANTED  = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_WOKEN    = 3'd2,
    EV_RELEASED = 3'd3,
    EV_UNDERFLOW = 3'd4,
    EV_QFULL    = 3'd5,
    EV_CFULL    = 3'd6
  } event_e;

  // queue control from the lock controller
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

/* design/rwl_cell.sv */
// one wait queue cell: holds an id, loads a new one or takes its neighbor's
`timescale 1ns / 1ps

module rwl_cell import rwl_pkg::*; #(
  parameter int unsigned ID_BITS = IdBitsDef
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               shift_i,
  input  logic [ID_BITS-1:0] load_id_i,
  input  logic [ID_BITS-1:0] next_id_i,
  output logic [ID_BITS-1:0] id_o
);

  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS-1:0] id_d;

  always_comb begin
    id_d = id_q;
    if (shift_i) begin
      id_d = next_id_i;
    end else if (load_i) begin
      id_d = load_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;

endmodule

/* design/rwl_queue.sv */
// wait queue built as a shifting chain of cells, head in cell zero
`timescale 1ns / 1ps

module rwl_queue import rwl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned ID_BITS     = IdBitsDef,
  localparam int unsigned FillW      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_ctrl_t            ctrl_i,
  input  logic [ID_BITS-1:0] push_id_i,
  output logic [ID_BITS-1:0] head_id_o,
  output logic [FillW-1:0]   fill_o
);

  logic [FillW-1:0]   fill_q;
  logic [FillW-1:0]   fill_d;
  logic [ID_BITS-1:0] cell_id [QUEUE_DEPTH+1];

  // past the last cell nothing valid shifts in
  assign cell_id[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rwl_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .load_i   (ctrl_i.push && (fill_q == FillW'(i))),
      .shift_i  (ctrl_i.pop),
      .load_id_i(push_id_i),
      .next_id_i(cell_id[i+1]),
      .id_o     (cell_id[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.push) begin
      fill_d = fill_q + FillW'(1);
    end else if (ctrl_i.pop) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign head_id_o = cell_id[0];
  assign fill_o    = fill_q;

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QUEUE_DEPTH))
    else $error("wait queue fill beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (fill_q != FillW'(QUEUE_DEPTH)) && !ctrl_i.pop)
    else $error("push into full queue or together with pop");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |=> fill_q == $past(fill_q) - FillW'(1))
    else $error("pop did not lower the fill count");

endmodule

/* design/reader_writer_lock_unit_top.sv */
// top level of the reader-writer lock unit: request decode and event output
`timescale 1ns / 1ps
//
// usage
// - slave stream carries one lock request per transaction: tuser holds the
//   action (read lock, read unlock, write lock, write unlock), tdata the
//   requester id
// - master stream carries events: tuser the event kind, tdata the id, the
//   lock mode and the reader count after the request, tlast marks the final
//   event caused by one request
// - most requests give one event, registered and shown in the cycle after acceptance
// - a release with waiting ids gives one woken event per cycle while the master side
//   is ready, up to 16, each read out of the head of the cell chain; the request is
//   taken at once, and no new request is accepted until the last woken event is registered
// - with the master side ready and no wake run in progress a request can be accepted every cycle
// - reset empties the queue count, frees the lock and clears the reader count
// - a stall on the master side holds the event register and blocks new
//   requests until the pending event is taken
module reader_writer_lock_unit_top import rwl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned ID_BITS     = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [5:0] requester_id, [7:6] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  // event stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [5:0] event_id, [7:6] lock_mode,
                                        // [15:8] readers_held
  output logic [2:0]  m_axis_tuser_o,   // [2:0] event_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAKE = 2'b10
  } state_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [WakeCntW-1:0] wake_q, wake_d;

  // output event register
  logic              ovalid_q, ovalid_d;
  event_e            okind_q, okind_d;
  logic [IdW-1:0]    oid_q, oid_d;
  mode_e             omode_q, omode_d;
  logic [CountW-1:0] ocnt_q, ocnt_d;
  logic              olast_q, olast_d;

  q_ctrl_t            q_ctrl;
  logic [ID_BITS-1:0] push_id;
  logic [ID_BITS-1:0] head_id;
  logic [FillW-1:0]   fill;
  logic [IdW-1:0]     req_id;
  logic [IdW-1:0]     req_id_m;
  logic [IdW-1:0]     head_id6;
  action_e            req_act;
  logic               slot_free;
  logic               accept;
  logic               q_full;

  assign req_id  = s_axis_tdata_i[IdW-1:0];
  assign req_act = action_e'(s_axis_tuser_i);

  // the queue stores ID_BITS of the id; both directions go through a wide copy
  assign push_id  = ID_BITS'(IdMaxBits'(req_id));
  assign head_id6 = IdW'(IdMaxBits'(head_id));
  // events report the id as the lock sees it, limited to ID_BITS
  assign req_id_m = IdW'(IdMaxBits'(push_id));

  assign slot_free = !ovalid_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign q_full    = (fill == FillW'(QUEUE_DEPTH));

  assign s_axis_tready_o = (state_q == ST_IDLE) && slot_free;

  rwl_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (q_ctrl),
    .push_id_i(push_id),
    .head_id_o(head_id),
    .fill_o   (fill)
  );

  always_comb begin
    logic emit;
    logic deny;
    logic rel;

    state_d  = state_q;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    wake_d   = wake_q;
    q_ctrl   = '0;
    emit     = 1'b0;
    deny     = 1'b0;
    rel      = 1'b0;
    okind_d  = okind_q;
    oid_d    = oid_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit    = 1'b1;
          oid_d   = req_id_m;
          olast_d = 1'b1;
          unique case (req_act)
            ACT_RD_LOCK: begin
              if (mode_q != MODE_WRITING) begin
                if (cnt_q == '1) begin
                  okind_d = EV_CFULL;
                end else begin
                  cnt_d   = cnt_q + CountW'(1);
                  mode_d  = MODE_READING;
                  okind_d = EV_GRANTED;
                end
              end else begin
                deny = 1'b1;
              end
            end
            ACT_RD_UNLOCK: begin
              if (cnt_q == '0) begin
                okind_d = EV_UNDERFLOW;
              end else begin
                cnt_d = cnt_q - CountW'(1);
                if (cnt_q == CountW'(1)) begin
                  rel = 1'b1;
                end else begin
                  okind_d = EV_GRANTED;
                end
              end
            end
            ACT_WR_LOCK: begin
              if (mode_q == MODE_FREE) begin
                mode_d  = MODE_WRITING;
                okind_d = EV_GRANTED;
              end else begin
                deny = 1'b1;
              end
            end
            ACT_WR_UNLOCK: begin
              if (mode_q != MODE_WRITING) begin
                okind_d = EV_UNDERFLOW;
              end else begin
                rel = 1'b1;
              end
            end
            default: okind_d = EV_UNDERFLOW;
          endcase

          // denied request goes to the tail unless the queue is full
          if (deny) begin
            if (q_full) begin
              okind_d = EV_QFULL;
            end else begin
              q_ctrl.push = 1'b1;
              okind_d     = EV_QUEUED;
            end
          end

          // release frees the lock and, if ids are waiting, starts waking the queue
          if (rel) begin
            mode_d = MODE_FREE;
            if (fill == '0) begin
              okind_d = EV_RELEASED;
            end else begin
              emit    = 1'b0;
              wake_d  = '0;
              state_d = ST_WAKE;
            end
          end
        end
      end
      ST_WAKE: begin
        if (slot_free) begin
          emit       = 1'b1;
          q_ctrl.pop = 1'b1;
          okind_d    = EV_WOKEN;
          oid_d      = head_id6;
          olast_d    = (fill == FillW'(1)) || (wake_q == WakeCntW'(MaxResults - 1));
          wake_d     = wake_q + WakeCntW'(1);
          if (olast_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      ovalid_d = 1'b1;
    end
    // mode and count after the request ride along with every event
    omode_d = emit ? mode_d : omode_q;
    ocnt_d  = emit ? cnt_d : ocnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= MODE_FREE;
      cnt_q    <= '0;
      wake_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      wake_q   <= wake_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oid_q   <= oid_d;
    omode_q <= omode_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tdata_o  = {ocnt_q, omode_q, oid_q};
  assign m_axis_tlast_o  = olast_q;

  a_wake_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAKE) |-> (fill != '0) && (mode_q == MODE_FREE))
    else $error("waking with an empty queue or a held lock");

  a_readers_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (mode_q == MODE_READING))
    else $error("readers held while lock not in reading mode");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready_i) |=> ovalid_q && $stable(okind_q) && $stable(oid_q))
    else $error("pending event changed during stall");

endmodule

/* tb/sv/reader_writer_lock_unit_top_tb.sv */
// self-checking testbench for the reader-writer lock unit: request streams against a lock predictor
`timescale 1ns / 1ps

module reader_writer_lock_unit_top_tb;
  import rwl_pkg::*;

  typedef struct packed {
    action_e    act;
    logic [5:0] id;
  } lock_req_t;

  typedef struct packed {
    event_e     kind;
    logic [5:0] id;
    mode_e      mode;
    logic [7:0] readers;
    logic       last;
  } lock_event_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // requests waiting to be driven, events waiting to be seen
  lock_req_t   pending_reqs[$];
  lock_event_t expected_events[$];

  // predicted lock state
  mode_e       lock_state = MODE_FREE;
  logic [7:0]  holders    = '0;
  logic [5:0]  waiters[$];

  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int err_count      = 0;
  int n_generated    = 0;
  int n_requests     = 0;
  int n_events       = 0;
  int kind_seen[8];

  reader_writer_lock_unit_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // lock predictor
  // ---------------------------------------------------------------------------

  // event snapshots the lock state as it stands after the update
  function automatic void post_event(event_e kind, logic [5:0] id, logic last);
    lock_event_t ev;
    ev.kind    = kind;
    ev.id      = id;
    ev.mode    = lock_state;
    ev.readers = holders;
    ev.last    = last;
    expected_events.push_back(ev);
  endfunction

  // denied request: park the id, or drop it when the wait list is full
  function automatic void park_or_refuse(logic [5:0] id);
    if (waiters.size() >= QueueDepthDef) begin
      post_event(EV_QFULL, id, 1'b1);
    end else begin
      waiters.push_back(id);
      post_event(EV_QUEUED, id, 1'b1);
    end
  endfunction

  // lock goes free; wake up to MaxResults waiters in arrival order
  function automatic void free_lock(logic [5:0] id);
    int n_wake;
    lock_state = MODE_FREE;
    if (waiters.size() == 0) begin
      post_event(EV_RELEASED, id, 1'b1);
    end else begin
      n_wake = (waiters.size() > MaxResults) ? MaxResults : waiters.size();
      for (int i = 0; i < n_wake; i++) begin
        post_event(EV_WOKEN, waiters.pop_front(), i == n_wake - 1);
      end
    end
  endfunction

  function automatic void predict_request(action_e act, logic [5:0] id);
    case (act)
      ACT_RD_LOCK: begin
        if (lock_state == MODE_WRITING) begin
          park_or_refuse(id);
        end else if (holders == 8'hff) begin
          post_event(EV_CFULL, id, 1'b1);
        end else begin
          holders++;
          lock_state = MODE_READING;
          post_event(EV_GRANTED, id, 1'b1);
        end
      end
      ACT_RD_UNLOCK: begin
        if (holders == 0) begin
          post_event(EV_UNDERFLOW, id, 1'b1);
        end else begin
          holders--;
          if (holders == 0) free_lock(id);
          else post_event(EV_GRANTED, id, 1'b1);
        end
      end
      ACT_WR_LOCK: begin
        if (lock_state == MODE_FREE) begin
          lock_state = MODE_WRITING;
          post_event(EV_GRANTED, id, 1'b1);
        end else begin
          park_or_refuse(id);
        end
      end
      default: begin
        if (lock_state != MODE_WRITING) post_event(EV_UNDERFLOW, id, 1'b1);
        else free_lock(id);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: predicts on each accepted transaction, then offers the next
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_driver
    lock_req_t next_req;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_request(action_e'(s_axis_tuser_i), s_axis_tdata_i[5:0]);
        n_requests++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= next_req.act;
          s_axis_tdata_i  <= {2'b00, next_req.id};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event monitor: compares each accepted transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : event_monitor
    lock_event_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_events++;
        kind_seen[m_axis_tuser_o]++;
        if (expected_events.size() == 0) begin
          report_mismatch("event with nothing expected, kind", m_axis_tuser_o, -1);
        end else begin
          want = expected_events.pop_front();
          if (m_axis_tuser_o != want.kind)
            report_mismatch("event_kind", m_axis_tuser_o, want.kind);
          if (m_axis_tdata_o[5:0] != want.id)
            report_mismatch("event_id", m_axis_tdata_o[5:0], want.id);
          if (m_axis_tdata_o[7:6] != want.mode)
            report_mismatch("lock_mode", m_axis_tdata_o[7:6], want.mode);
          if (m_axis_tdata_o[15:8] != want.readers)
            report_mismatch("readers_held", m_axis_tdata_o[15:8], want.readers);
          if (m_axis_tlast_o != want.last)
            report_mismatch("last_of_run", m_axis_tlast_o, want.last);
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [5:0] rand_id();
    return 6'($urandom_range(63));
  endfunction

  function automatic void add_req(action_e act, logic [5:0] id);
    lock_req_t r;
    r.act = act;
    r.id  = id;
    pending_reqs.push_back(r);
    n_generated++;
  endfunction

  // writer holds the lock while others contend; sometimes enough to overflow
  function automatic void gen_writer_session();
    logic [5:0] owner;
    int n_contend;
    owner     = rand_id();
    n_contend = ($urandom_range(9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
    add_req(ACT_WR_LOCK, owner);
    repeat (n_contend) add_req($urandom_range(1) ? ACT_RD_LOCK : ACT_WR_LOCK, rand_id());
    add_req(ACT_WR_UNLOCK, owner);
  endfunction

  // a group of readers with writers trying to get in between
  function automatic void gen_reader_session();
    logic [5:0] ids[$];
    int k;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      ids.push_back(rand_id());
      add_req(ACT_RD_LOCK, ids[i]);
      if ($urandom_range(2) == 0) add_req(ACT_WR_LOCK, rand_id());
    end
    for (int i = 0; i < k; i++) begin
      add_req(ACT_RD_UNLOCK, ids[i]);
      if ($urandom_range(5) == 0) add_req(ACT_WR_LOCK, rand_id());
    end
  endfunction

  // stray request, leaning toward unlocks so held readers tend to drain
  function automatic void gen_noise();
    int pick;
    pick = $urandom_range(7);
    if (pick < 4)      add_req(ACT_RD_UNLOCK, rand_id());
    else if (pick < 6) add_req(ACT_WR_UNLOCK, rand_id());
    else               add_req(action_e'($urandom_range(3)), rand_id());
  endfunction

  function automatic void gen_mix(int count);
    int start;
    int pick;
    start = n_generated;
    while (n_generated - start < count) begin
      pick = $urandom_range(9);
      if (pick < 4)      gen_reader_session();
      else if (pick < 8) gen_writer_session();
      else               gen_noise();
    end
  endfunction

  // drive reader count to its ceiling with writers contending
  function automatic void gen_reader_flood();
    for (int i = 0; i < 257; i++) begin
      add_req(ACT_RD_LOCK, rand_id());
      if ($urandom_range(14) == 0) add_req(ACT_WR_LOCK, rand_id());
    end
  endfunction

  // hold the sender until every outstanding event has been seen
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || s_axis_tvalid_i || expected_events.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int sink_pct);
    send_idle_pct  = send_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: underflows, contention, a full wait list, both release paths
    set_idling(0, 0);
    add_req(ACT_RD_UNLOCK, 6'd0);        // unlock with no readers
    add_req(ACT_WR_UNLOCK, 6'd63);       // write unlock while free
    add_req(ACT_RD_LOCK,   6'd0);
    add_req(ACT_WR_UNLOCK, 6'd21);       // write unlock while reading
    add_req(ACT_WR_LOCK,   6'd42);       // writer waits behind reader
    add_req(ACT_RD_UNLOCK, 6'd0);        // last reader leaves, one woken
    add_req(ACT_WR_LOCK,   6'd63);
    for (int i = 0; i < 16; i++)
      add_req((i % 2) ? ACT_WR_LOCK : ACT_RD_LOCK, 6'(i * 4 + 1));
    add_req(ACT_RD_LOCK,   6'd55);       // wait list full, id dropped
    add_req(ACT_WR_UNLOCK, 6'd63);       // sixteen woken in one burst
    add_req(ACT_WR_LOCK,   6'd22);
    add_req(ACT_WR_UNLOCK, 6'd22);       // release with nobody waiting
    wait_quiet();

    set_idling(60, 0);
    gen_mix(30);
    wait_quiet();

    set_idling(29, 29);
    gen_mix(30);
    wait_quiet();

    set_idling(0, 60);
    gen_reader_flood();
    wait_quiet();

    // let any stray event show up before the verdict
    repeat (20) @(posedge clk_i);
    if (expected_events.size() != 0)
      report_mismatch("events still expected at end", 0, expected_events.size());

    $display("covered %0d requests, %0d events: granted %0d, queued %0d, woken %0d",
             n_requests, n_events, kind_seen[EV_GRANTED], kind_seen[EV_QUEUED],
             kind_seen[EV_WOKEN]);
    $display("released idle %0d, underflow %0d, wait list full %0d, reader count full %0d",
             kind_seen[EV_RELEASED], kind_seen[EV_UNDERFLOW], kind_seen[EV_QFULL],
             kind_seen[EV_CFULL]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3000000;
    $display("[%0t] timeout with %0d requests pending, %0d events expected", $realtime,
             pending_reqs.size(), expected_events.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
